/* design/dtf_pkg.sv */
// Shared types, character codes and the power-of-ten table for the decimal text converter.
`timescale 1ns / 1ps

package dtf_pkg;

	// Parser phases, following the grammar of a decimal number.
	typedef enum logic [2:0] {
		PH_LEAD  = 3'd0,
		PH_INT   = 3'd1,
		PH_POINT = 3'd2,
		PH_FRAC  = 3'd3,
		PH_ERR   = 3'd4
	} phase_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		CS_PARSE  = 2'd0,
		CS_DIVIDE = 2'd1,
		CS_FINISH = 2'd2
	} ctl_state_t;

	localparam int FRAC_VALUE_BITS     = 30;
	localparam int FRAC_COUNT_BITS     = 4;
	localparam int MAX_FRACTION_DIGITS = 9;
	localparam int FRAC_OUT_BITS       = 32;
	localparam int DIV_STEPS           = 32;
	localparam int DIV_COUNT_BITS      = 5;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_BLANK = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_POINT = 8'd46;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	// Ten to the power n for the kept fraction digit count.
	function automatic logic [FRAC_VALUE_BITS-1:0] pow10(input logic [FRAC_COUNT_BITS-1:0] n);
		logic [FRAC_VALUE_BITS-1:0] p;
		case (n)
			4'd1:    p = 30'd10;
			4'd2:    p = 30'd100;
			4'd3:    p = 30'd1000;
			4'd4:    p = 30'd10000;
			4'd5:    p = 30'd100000;
			4'd6:    p = 30'd1000000;
			4'd7:    p = 30'd10000000;
			4'd8:    p = 30'd100000000;
			4'd9:    p = 30'd1000000000;
			default: p = 30'd1;
		endcase
		return p;
	endfunction

endpackage

/* design/decimal_text_to_fixed.sv */
// Top level: character-serial decimal text parser with a shared restoring divider.
// The block reads a decimal number one character item at a time and returns one
// signed Q31.32 result item when it sees the zero terminator. Leading blanks and
// control codes 9 to 13 are skipped, then an optional sign, integer digits, and an
// optional point that must be followed by at least one fraction digit. Every
// character other than the terminator is taken without a stall. The terminator
// leads straight to the finishing state when there are no fraction digits (or on
// a syntax error or saturation); otherwise the kept fraction digits, read as an
// integer, are divided by the matching power of ten over 32 steps of one shared
// compare-and-subtract unit, one quotient bit per cycle, followed by the finishing
// state, which applies the sign and loads the output register. While the divider
// runs, ch_stall is high. The result sits in an output register, so the next
// number's characters are accepted while a finished result waits to be taken.
// bad_syntax reports an illegal character or a point with no digits after it and
// forces the value to zero; saturated reports that the integer part passed
// 2^WHOLE_BITS - 1, in which case the largest magnitude is returned with the sign.
// Fraction digits beyond the ninth are checked but dropped.
`timescale 1ns / 1ps

module decimal_text_to_fixed
	import dtf_pkg::*;
#(
	parameter int WHOLE_BITS = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ch_valid,
	output logic               ch_stall,
	input  logic [7:0]         ch,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [63:0] value,
	output logic               bad_syntax,
	output logic               saturated
);

	localparam int WN_BITS = WHOLE_BITS + 4;

	// Parser state.
	phase_t                       phase_q, phase_d;
	logic                         negative_q;
	logic [WHOLE_BITS-1:0]        whole_q;
	logic [FRAC_VALUE_BITS-1:0]   fdv_q;
	logic [FRAC_COUNT_BITS-1:0]   fcnt_q;
	logic                         clamped_q;

	// Sequencer and divider state.
	ctl_state_t                   state_q, state_d;
	logic [FRAC_VALUE_BITS-1:0]   rem_q;
	logic [FRAC_OUT_BITS-1:0]     quo_q;
	logic [DIV_COUNT_BITS-1:0]    div_cnt_q;

	// Output register.
	logic                         res_valid_q;
	logic [63:0]                  value_q;
	logic                         bad_q;
	logic                         sat_q;

	// Character classification.
	logic       is_digit, is_blank, is_sign, is_term;
	logic [3:0] dval;
	logic       take_whole, take_frac, set_sign;

	always_comb begin
		is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_blank = (ch == CH_BLANK) || ((ch >= CH_TAB) && (ch <= CH_CR));
		is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
		is_term  = (ch == CH_NUL);
		dval     = 4'(ch - CH_ZERO);
	end

	// Grammar: next phase and which accumulator a digit goes to.
	always_comb begin
		phase_d    = phase_q;
		take_whole = 1'b0;
		take_frac  = 1'b0;
		set_sign   = 1'b0;
		case (phase_q)
			PH_LEAD: begin
				if (is_blank) begin
					phase_d = PH_LEAD;
				end else if (is_sign) begin
					set_sign = 1'b1;
					phase_d  = PH_INT;
				end else if (is_digit) begin
					take_whole = 1'b1;
					phase_d    = PH_INT;
				end else if (ch == CH_POINT) begin
					phase_d = PH_POINT;
				end else begin
					phase_d = PH_ERR;
				end
			end
			PH_INT: begin
				if (is_digit) begin
					take_whole = 1'b1;
				end else if (ch == CH_POINT) begin
					phase_d = PH_POINT;
				end else begin
					phase_d = PH_ERR;
				end
			end
			PH_POINT, PH_FRAC: begin
				if (is_digit) begin
					take_frac = 1'b1;
					phase_d   = PH_FRAC;
				end else begin
					phase_d = PH_ERR;
				end
			end
			default: begin
				phase_d = PH_ERR;
			end
		endcase
	end

	// Integer accumulator: times ten plus digit, clamped at the all-ones bound.
	logic [WN_BITS-1:0] whole_ext, whole_next;
	logic               whole_over;

	always_comb begin
		whole_ext  = WN_BITS'(whole_q);
		whole_next = (whole_ext << 3) + (whole_ext << 1) + WN_BITS'(dval);
		whole_over = |whole_next[WN_BITS-1:WHOLE_BITS];
	end

	// Fraction accumulator; the count limit keeps the value inside 30 bits.
	logic [FRAC_VALUE_BITS+3:0] fdv_ext, fdv_next;
	logic                       frac_room;

	always_comb begin
		fdv_ext   = (FRAC_VALUE_BITS + 4)'(fdv_q);
		fdv_next  = (fdv_ext << 3) + (fdv_ext << 1) + (FRAC_VALUE_BITS + 4)'(dval);
		frac_room = fcnt_q < FRAC_COUNT_BITS'(MAX_FRACTION_DIGITS);
	end

	// Shared divider step: one restoring compare-and-subtract per cycle.
	logic [FRAC_VALUE_BITS-1:0] divisor;
	logic [FRAC_VALUE_BITS:0]   rem2;
	logic [FRAC_VALUE_BITS+1:0] diff;
	logic                       ge;

	always_comb begin
		divisor = pow10(fcnt_q);
		rem2    = {rem_q, 1'b0};
		diff    = (FRAC_VALUE_BITS + 2)'(rem2) - (FRAC_VALUE_BITS + 2)'(divisor);
		ge      = ~diff[FRAC_VALUE_BITS+1];
	end

	// Result assembly in the finishing cycle.
	logic        bad_now, need_div;
	logic [63:0] mag, signed_mag;

	always_comb begin
		bad_now  = (phase_q == PH_ERR) || (phase_q == PH_POINT);
		need_div = !bad_now && !clamped_q && (fcnt_q != '0);
		if (bad_now) begin
			mag = '0;
		end else if (clamped_q) begin
			mag = (64'd1 << (WHOLE_BITS + FRAC_OUT_BITS)) - 64'd1;
		end else begin
			mag = (64'(whole_q) << FRAC_OUT_BITS) | 64'(quo_q);
		end
		signed_mag = (negative_q && !bad_now) ? (~mag + 64'd1) : mag;
	end

	// Sequencer.
	logic ch_take, div_start, div_step, res_load;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_step  = 1'b0;
		res_load  = 1'b0;
		ch_take   = 1'b0;
		case (state_q)
			CS_PARSE: begin
				ch_take = ch_valid;
				if (ch_valid && is_term) begin
					div_start = 1'b1;
					state_d   = need_div ? CS_DIVIDE : CS_FINISH;
				end
			end
			CS_DIVIDE: begin
				div_step = 1'b1;
				if (div_cnt_q == DIV_COUNT_BITS'(DIV_STEPS - 1)) begin
					state_d = CS_FINISH;
				end
			end
			CS_FINISH: begin
				if (!res_valid_q || !res_stall) begin
					res_load = 1'b1;
					state_d  = CS_PARSE;
				end
			end
			default: begin
				state_d = CS_PARSE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_PARSE;
		end else begin
			state_q <= state_d;
		end
	end

	// Parser registers; they return to reset values once the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEAD;
			negative_q <= 1'b0;
			whole_q    <= '0;
			fdv_q      <= '0;
			fcnt_q     <= '0;
			clamped_q  <= 1'b0;
		end else if (res_load) begin
			phase_q    <= PH_LEAD;
			negative_q <= 1'b0;
			whole_q    <= '0;
			fdv_q      <= '0;
			fcnt_q     <= '0;
			clamped_q  <= 1'b0;
		end else if (ch_take && !is_term) begin
			phase_q <= phase_d;
			if (set_sign) begin
				negative_q <= (ch == CH_MINUS);
			end
			if (take_whole) begin
				if (whole_over) begin
					whole_q   <= '1;
					clamped_q <= 1'b1;
				end else begin
					whole_q <= whole_next[WHOLE_BITS-1:0];
				end
			end
			if (take_frac && frac_room) begin
				fdv_q  <= fdv_next[FRAC_VALUE_BITS-1:0];
				fcnt_q <= fcnt_q + 1'b1;
			end
		end
	end

	// Divider registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_start) begin
			div_cnt_q <= '0;
		end else if (div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			rem_q <= fdv_q;
			quo_q <= '0;
		end else if (div_step) begin
			rem_q <= ge ? diff[FRAC_VALUE_BITS-1:0] : rem2[FRAC_VALUE_BITS-1:0];
			quo_q <= {quo_q[FRAC_OUT_BITS-2:0], ge};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			value_q <= signed_mag;
			bad_q   <= bad_now;
			sat_q   <= !bad_now && clamped_q;
		end
	end

	assign ch_stall   = (state_q != CS_PARSE);
	assign res_valid  = res_valid_q;
	assign value      = signed'(value_q);
	assign bad_syntax = bad_q;
	assign saturated  = sat_q;

	// The remainder of a restoring division always stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_DIVIDE) |-> (rem_q < divisor))
		else $error("divider remainder reached the divisor");

	// The last divider step always hands over to the finishing cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_DIVIDE && div_cnt_q == DIV_COUNT_BITS'(DIV_STEPS - 1))
		|=> (state_q == CS_FINISH))
		else $error("divider did not finish after its last step");

	// A new result only appears out of the finishing cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == CS_FINISH))
		else $error("result appeared without a finishing cycle");

	// The kept fraction digit count never passes its limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FRAC_COUNT_BITS'(MAX_FRACTION_DIGITS))
		else $error("fraction digit count passed its limit");

	// Saturation and a syntax error are never reported together.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(bad_q && sat_q))
		else $error("both error flags set on one result");

endmodule
